### sv/lprd_pkg.sv
// ============================================================================
// lprd_pkg
// Shared widths and result codes for the length-prefixed record deframer.
// ============================================================================
package lprd_pkg;

    // Field widths of the byte stream and of the captured length headers.
    localparam int BYTE_W    = 8;
    localparam int KIND_W    = 2;
    localparam int NAMELEN_W = 16;
    localparam int LEN32_W   = 32;
    localparam int HDRCNT_W  = 2;

    // Result kind codes.
    localparam logic [KIND_W-1:0] KIND_NAME    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END     = 2'd2;

    // Index of the final byte of the two-byte and four-byte length headers.
    localparam logic [HDRCNT_W-1:0] HDR_LAST_2B = 2'd1;
    localparam logic [HDRCNT_W-1:0] HDR_LAST_4B = 2'd3;

endpackage

### sv/length_prefixed_record_deframer.sv
// ============================================================================
// length_prefixed_record_deframer
// Splits a byte stream of length-prefixed records into tagged name and
// payload bytes.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_byte) carries one raw byte
//   per transfer. Each record is a 4-byte big-endian outer length, a 2-byte
//   big-endian name length, the name bytes, a 4-byte big-endian payload
//   length and the payload bytes. Header bytes produce no output transfer.
//   Output channel (o_out_valid / i_out_ready) carries one tagged byte per
//   name or payload byte, or a single end marker for an empty payload, along
//   with the lengths of the current record.
//   Throughput is one input byte per cycle. A result appears on the output
//   in the cycle after its input byte is accepted, held in a single output
//   register. The frame state advances as each byte is accepted, so the
//   block keeps taking bytes as long as the output register is empty or is
//   being drained in the same cycle.
//   When the receiver stalls with a result held, o_in_ready drops and the
//   held result stays unchanged until taken.
//   Reset returns the parser to the outer length phase with all captured
//   lengths cleared and the output register empty.
// ============================================================================
module length_prefixed_record_deframer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [lprd_pkg::BYTE_W-1:0]     i_in_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [lprd_pkg::KIND_W-1:0]     o_kind,
    output logic [lprd_pkg::BYTE_W-1:0]     o_value,
    output logic                            o_field_last,
    output logic                            o_record_end,
    output logic [lprd_pkg::NAMELEN_W-1:0]  o_name_length,
    output logic [lprd_pkg::LEN32_W-1:0]    o_payload_length,
    output logic [lprd_pkg::LEN32_W-1:0]    o_outer_length
);
    import lprd_pkg::*;

    typedef enum logic [2:0] {
        PH_OUTER   = 3'd0,
        PH_NAMELEN = 3'd1,
        PH_NAME    = 3'd2,
        PH_PAYLEN  = 3'd3,
        PH_PAYLOAD = 3'd4
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [HDRCNT_W-1:0]    r_hdr_cnt, n_hdr_cnt;
    logic [LEN32_W-1:0]     r_outer_len, n_outer_len;
    logic [NAMELEN_W-1:0]   r_name_len, n_name_len;
    logic [LEN32_W-1:0]     r_pay_len, n_pay_len;
    logic [LEN32_W-1:0]     r_remain, n_remain;

    logic                   n_emit;
    logic [KIND_W-1:0]      n_kind;
    logic [BYTE_W-1:0]      n_value;
    logic                   n_last;
    logic                   n_rend;
    logic [LEN32_W-1:0]     dec_remain;

    logic                   r_out_valid;
    logic [KIND_W-1:0]      r_kind;
    logic [BYTE_W-1:0]      r_value;
    logic                   r_last;
    logic                   r_rend;
    logic [NAMELEN_W-1:0]   r_o_name_len;
    logic [LEN32_W-1:0]     r_o_pay_len;
    logic [LEN32_W-1:0]     r_o_outer_len;

    logic                   in_xfer;

    // The output register frees up when empty or drained this cycle.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;

    // Saturating countdown of the bytes left in the current field.
    assign dec_remain = (r_remain != '0) ? (r_remain - LEN32_W'(1)) : r_remain;

    // Frame parser: next state and the result for the byte on the input.
    always_comb begin
        n_phase     = r_phase;
        n_hdr_cnt   = r_hdr_cnt;
        n_outer_len = r_outer_len;
        n_name_len  = r_name_len;
        n_pay_len   = r_pay_len;
        n_remain    = r_remain;
        n_emit      = 1'b0;
        n_kind      = KIND_NAME;
        n_value     = i_in_byte;
        n_last      = 1'b0;
        n_rend      = 1'b0;
        case (r_phase)
            PH_NAMELEN: begin
                n_name_len = {r_name_len[NAMELEN_W-BYTE_W-1:0], i_in_byte};
                if (r_hdr_cnt >= HDR_LAST_2B) begin
                    n_hdr_cnt = '0;
                    if (n_name_len == '0) begin
                        n_phase = PH_PAYLEN;
                    end else begin
                        n_remain = LEN32_W'(n_name_len);
                        n_phase  = PH_NAME;
                    end
                end else begin
                    n_hdr_cnt = r_hdr_cnt + HDRCNT_W'(1);
                end
            end
            PH_NAME: begin
                n_remain = dec_remain;
                n_emit   = 1'b1;
                n_kind   = KIND_NAME;
                n_last   = (dec_remain == '0);
                if (n_last) begin
                    n_phase = PH_PAYLEN;
                end
            end
            PH_PAYLEN: begin
                n_pay_len = {r_pay_len[LEN32_W-BYTE_W-1:0], i_in_byte};
                if (r_hdr_cnt >= HDR_LAST_4B) begin
                    n_hdr_cnt = '0;
                    if (n_pay_len == '0) begin
                        // Empty payload closes the record with an end marker.
                        n_emit  = 1'b1;
                        n_kind  = KIND_END;
                        n_value = '0;
                        n_rend  = 1'b1;
                        n_phase = PH_OUTER;
                    end else begin
                        n_remain = n_pay_len;
                        n_phase  = PH_PAYLOAD;
                    end
                end else begin
                    n_hdr_cnt = r_hdr_cnt + HDRCNT_W'(1);
                end
            end
            PH_PAYLOAD: begin
                n_remain = dec_remain;
                n_emit   = 1'b1;
                n_kind   = KIND_PAYLOAD;
                n_last   = (dec_remain == '0);
                n_rend   = n_last;
                if (n_last) begin
                    n_phase = PH_OUTER;
                end
            end
            default: begin
                // Outer length; unused phase codes land here as well.
                if (r_hdr_cnt == '0) begin
                    n_name_len  = '0;
                    n_pay_len   = '0;
                    n_outer_len = LEN32_W'(i_in_byte);
                end else begin
                    n_outer_len = {r_outer_len[LEN32_W-BYTE_W-1:0], i_in_byte};
                end
                if (r_hdr_cnt >= HDR_LAST_4B) begin
                    n_hdr_cnt = '0;
                    n_phase   = PH_NAMELEN;
                end else begin
                    n_hdr_cnt = r_hdr_cnt + HDRCNT_W'(1);
                    n_phase   = PH_OUTER;
                end
            end
        endcase
    end

    // Parser state advances on each accepted input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_OUTER;
            r_hdr_cnt   <= '0;
            r_outer_len <= '0;
            r_name_len  <= '0;
            r_pay_len   <= '0;
            r_remain    <= '0;
        end else if (in_xfer) begin
            r_phase     <= n_phase;
            r_hdr_cnt   <= n_hdr_cnt;
            r_outer_len <= n_outer_len;
            r_name_len  <= n_name_len;
            r_pay_len   <= n_pay_len;
            r_remain    <= n_remain;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer && n_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (in_xfer && n_emit) begin
            r_kind        <= n_kind;
            r_value       <= n_value;
            r_last        <= n_last;
            r_rend        <= n_rend;
            r_o_name_len  <= n_name_len;
            r_o_pay_len   <= n_pay_len;
            r_o_outer_len <= n_outer_len;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_kind;
    assign o_value          = r_value;
    assign o_field_last     = r_last;
    assign o_record_end     = r_rend;
    assign o_name_length    = r_o_name_len;
    assign o_payload_length = r_o_pay_len;
    assign o_outer_length   = r_o_outer_len;

endmodule

### sv/lprd_checker.sv
// ============================================================================
// lprd_checker
// Port-level checks for the length-prefixed record deframer.
// ============================================================================
module lprd_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            o_in_ready,
    input  logic                            o_out_valid,
    input  logic                            i_out_ready,
    input  logic [lprd_pkg::KIND_W-1:0]     o_kind,
    input  logic [lprd_pkg::BYTE_W-1:0]     o_value,
    input  logic                            o_field_last,
    input  logic                            o_record_end,
    input  logic [lprd_pkg::NAMELEN_W-1:0]  o_name_length,
    input  logic [lprd_pkg::LEN32_W-1:0]    o_payload_length
);
    import lprd_pkg::*;

    // A stalled output transfer keeps its valid and its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_kind) && $stable(o_value)
            && $stable(o_record_end) && $stable(o_payload_length))
        else $error("output transfer changed while stalled");

    // The input side is never blocked while the output register is empty.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output register");

    // An end marker carries no byte and always closes the record.
    a_end_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_END |->
            o_record_end && !o_field_last && o_value == '0 && o_payload_length == '0)
        else $error("malformed empty-payload end marker");

    // Name bytes never close a record; payload bytes close it on their last byte.
    a_record_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_NAME || o_kind == KIND_PAYLOAD) |->
            (o_record_end == (o_kind == KIND_PAYLOAD && o_field_last)))
        else $error("record end flag inconsistent with field");

    // A name byte is only seen once a nonzero name length was taken.
    a_name_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_NAME |-> o_name_length != '0)
        else $error("name byte with zero name length");

endmodule

bind length_prefixed_record_deframer lprd_checker u_lprd_checker (.*);

### tb/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking testbench for length_prefixed_record_deframer.
// A short table of hand-built records runs first; a stream of random
// well-formed records follows. Expected name, payload and end-marker transfers
// come from the table rows or from a cycle-free model of the framing state and
// are compared field by field with every transfer that the block sends out.
// ============================================================================
module tb;
    import lprd_pkg::*;

    // Clock, reset and block connections.
    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic [BYTE_W-1:0]    i_in_byte  = '0;
    logic                 i_out_ready = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [KIND_W-1:0]    o_kind;
    logic [BYTE_W-1:0]    o_value;
    logic                 o_field_last;
    logic                 o_record_end;
    logic [NAMELEN_W-1:0] o_name_length;
    logic [LEN32_W-1:0]   o_payload_length;
    logic [LEN32_W-1:0]   o_outer_length;

    // One tagged byte or end marker as the block gives it out.
    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [BYTE_W-1:0]    value;
        logic                 field_last;
        logic                 record_end;
        logic [NAMELEN_W-1:0] name_length;
        logic [LEN32_W-1:0]   payload_length;
        logic [LEN32_W-1:0]   outer_length;
    } deframed_t;

    // One row of the directed table.
    typedef struct {
        logic [BYTE_W-1:0] data;
        bit                typed;   // the expected outcome is written in the row
        bit                gives;   // typed rows: the byte yields a transfer
        deframed_t         exp;
    } dir_row_t;

    typedef enum logic [2:0] {
        PH_OUTER_LEN,
        PH_NAME_LEN,
        PH_NAME,
        PH_PAY_LEN,
        PH_PAYLOAD
    } deframe_phase_e;

    // Framing state of the model.
    deframe_phase_e       pr_phase;
    logic [HDRCNT_W-1:0]  pr_hdr_pos;
    logic [LEN32_W-1:0]   pr_outer_len;
    logic [NAMELEN_W-1:0] pr_name_len;
    logic [LEN32_W-1:0]   pr_pay_len;
    logic [LEN32_W-1:0]   pr_left;

    deframed_t due_results[$];
    dir_row_t  dir_tab[$];

    int  err_cnt      = 0;
    int  bytes_sent   = 0;
    int  records_sent = 0;
    int  name_seen    = 0;
    int  payload_seen = 0;
    int  end_seen     = 0;
    bit  gaps_on      = 1'b0;
    bit  stalls_on    = 1'b0;
    int  stall_left   = 0;

    length_prefixed_record_deframer u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_in_byte        (i_in_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_kind           (o_kind),
        .o_value          (o_value),
        .o_field_last     (o_field_last),
        .o_record_end     (o_record_end),
        .o_name_length    (o_name_length),
        .o_payload_length (o_payload_length),
        .o_outer_length   (o_outer_length)
    );

    always #10 i_clk = ~i_clk;

    // Runaway guard, far above the slowest correct run.
    initial begin
        #20_000_000;
        $display("Timeout with %0d transfers still awaited.", due_results.size());
        $display("[length_prefixed_record_deframer] ERROR");
        $finish;
    end

    // Prints one line per mismatch and counts every one.
    task automatic report_mismatch(input string msg);
        err_cnt++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    function automatic deframed_t make_res(input logic [KIND_W-1:0] kind,
                                           input logic [BYTE_W-1:0] value,
                                           input logic last, input logic rend,
                                           input logic [NAMELEN_W-1:0] nlen,
                                           input logic [LEN32_W-1:0] plen,
                                           input logic [LEN32_W-1:0] olen);
        deframed_t r;
        r.kind           = kind;
        r.value          = value;
        r.field_last     = last;
        r.record_end     = rend;
        r.name_length    = nlen;
        r.payload_length = plen;
        r.outer_length   = olen;
        return r;
    endfunction

    // Advances the framing state by one byte and says what it gives out.
    task automatic deframe_byte(input logic [BYTE_W-1:0] b, output bit got,
                                output deframed_t res);
        got = 1'b0;
        res = '0;
        case (pr_phase)
            PH_NAME_LEN: begin
                pr_name_len = {pr_name_len[7:0], b};
                if (pr_hdr_pos >= HDR_LAST_2B) begin
                    pr_hdr_pos = '0;
                    if (pr_name_len == '0) begin
                        pr_phase = PH_PAY_LEN;
                    end else begin
                        pr_left  = {16'h0000, pr_name_len};
                        pr_phase = PH_NAME;
                    end
                end else begin
                    pr_hdr_pos++;
                end
            end
            PH_NAME: begin
                if (pr_left != '0) pr_left--;
                res = make_res(KIND_NAME, b, pr_left == '0, 1'b0,
                               pr_name_len, pr_pay_len, pr_outer_len);
                got = 1'b1;
                if (pr_left == '0) pr_phase = PH_PAY_LEN;
            end
            PH_PAY_LEN: begin
                pr_pay_len = {pr_pay_len[23:0], b};
                if (pr_hdr_pos >= HDR_LAST_4B) begin
                    pr_hdr_pos = '0;
                    if (pr_pay_len == '0) begin
                        // Empty payload closes the record with an end marker.
                        res = make_res(KIND_END, '0, 1'b0, 1'b1,
                                       pr_name_len, pr_pay_len, pr_outer_len);
                        got = 1'b1;
                        pr_phase = PH_OUTER_LEN;
                    end else begin
                        pr_left  = pr_pay_len;
                        pr_phase = PH_PAYLOAD;
                    end
                end else begin
                    pr_hdr_pos++;
                end
            end
            PH_PAYLOAD: begin
                if (pr_left != '0) pr_left--;
                res = make_res(KIND_PAYLOAD, b, pr_left == '0, pr_left == '0,
                               pr_name_len, pr_pay_len, pr_outer_len);
                got = 1'b1;
                if (pr_left == '0) pr_phase = PH_OUTER_LEN;
            end
            default: begin
                // The first outer length byte starts a new record.
                if (pr_hdr_pos == '0) begin
                    pr_name_len  = '0;
                    pr_pay_len   = '0;
                    pr_outer_len = {24'h000000, b};
                end else begin
                    pr_outer_len = {pr_outer_len[23:0], b};
                end
                if (pr_hdr_pos >= HDR_LAST_4B) begin
                    pr_hdr_pos = '0;
                    pr_phase   = PH_NAME_LEN;
                end else begin
                    pr_hdr_pos++;
                    pr_phase = PH_OUTER_LEN;
                end
            end
        endcase
    endtask

    // Offers one byte, waits for its transfer, then records what it should give.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed,
                             input bit gives, input deframed_t exp);
        int        gap;
        bit        got;
        deframed_t res;
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 9);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        bytes_sent++;
        deframe_byte(b, got, res);
        if (typed) begin
            if (gives) due_results.push_back(exp);
        end else if (got) begin
            due_results.push_back(res);
        end
    endtask

    // Builds one well-formed record with random content and sends it.
    task automatic send_record(input bit big);
        logic [BYTE_W-1:0]    rec[$];
        int unsigned          nlen;
        int unsigned          plen;
        logic [LEN32_W-1:0]   olen;
        logic [NAMELEN_W-1:0] nl16;
        logic [LEN32_W-1:0]   pl32;
        deframed_t            none;
        none = '0;
        nlen = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
        plen = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
        if (big) begin
            if ($urandom_range(0, 1) == 0) nlen = $urandom_range(256, 300);
            else                           plen = $urandom_range(256, 320);
        end
        // Half the records carry an outer length that does not match at all.
        if ($urandom_range(0, 1) == 0) olen = 6 + nlen + plen;
        else                           olen = $urandom;
        nl16 = nlen[15:0];
        pl32 = plen;
        rec.push_back(olen[31:24]);
        rec.push_back(olen[23:16]);
        rec.push_back(olen[15:8]);
        rec.push_back(olen[7:0]);
        rec.push_back(nl16[15:8]);
        rec.push_back(nl16[7:0]);
        repeat (nlen) rec.push_back(8'($urandom_range(0, 255)));
        rec.push_back(pl32[31:24]);
        rec.push_back(pl32[23:16]);
        rec.push_back(pl32[15:8]);
        rec.push_back(pl32[7:0]);
        repeat (plen) rec.push_back(8'($urandom_range(0, 255)));
        foreach (rec[i]) send_byte(rec[i], 1'b0, 1'b0, none);
        records_sent++;
    endtask

    // Receiver: stalls in random bursts while enabled.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else if (stalls_on && $urandom_range(0, 5) == 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= $urandom_range(0, 8);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Compares every output transfer with the oldest expectation.
    always @(posedge i_clk) begin
        deframed_t e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("unexpected transfer kind %0d value 0x%02h",
                                          o_kind, o_value));
            end else begin
                e = due_results.pop_front();
                case (e.kind)
                    KIND_NAME:    name_seen++;
                    KIND_PAYLOAD: payload_seen++;
                    default:      end_seen++;
                endcase
                if (o_kind !== e.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", o_kind, e.kind));
                if (o_value !== e.value)
                    report_mismatch($sformatf("value 0x%02h, want 0x%02h",
                                              o_value, e.value));
                if (o_field_last !== e.field_last)
                    report_mismatch($sformatf("field_last %0b, want %0b",
                                              o_field_last, e.field_last));
                if (o_record_end !== e.record_end)
                    report_mismatch($sformatf("record_end %0b, want %0b",
                                              o_record_end, e.record_end));
                if (o_name_length !== e.name_length)
                    report_mismatch($sformatf("name_length %0d, want %0d",
                                              o_name_length, e.name_length));
                if (o_payload_length !== e.payload_length)
                    report_mismatch($sformatf("payload_length %0d, want %0d",
                                              o_payload_length, e.payload_length));
                if (o_outer_length !== e.outer_length)
                    report_mismatch($sformatf("outer_length 0x%08h, want 0x%08h",
                                              o_outer_length, e.outer_length));
            end
        end
    end

    // Row builders for the directed table.
    task automatic add_hdr(input logic [BYTE_W-1:0] b);
        dir_row_t r;
        r.data  = b;
        r.typed = 1'b1;
        r.gives = 1'b0;
        r.exp   = '0;
        dir_tab.push_back(r);
    endtask

    task automatic add_typed(input logic [BYTE_W-1:0] b, input deframed_t exp);
        dir_row_t r;
        r.data  = b;
        r.typed = 1'b1;
        r.gives = 1'b1;
        r.exp   = exp;
        dir_tab.push_back(r);
    endtask

    task automatic add_plain(input logic [BYTE_W-1:0] b);
        dir_row_t r;
        r.data  = b;
        r.typed = 1'b0;
        r.gives = 1'b0;
        r.exp   = '0;
        dir_tab.push_back(r);
    endtask

    // Main sequence.
    initial begin
        int bigs_left;
        bit paused;
        bigs_left = 2;
        paused    = 1'b0;

        pr_phase     = PH_OUTER_LEN;
        pr_hdr_pos   = '0;
        pr_outer_len = '0;
        pr_name_len  = '0;
        pr_pay_len   = '0;
        pr_left      = '0;

        // Record with the largest outer length, empty name and empty payload.
        repeat (4) add_hdr(8'hFF);
        repeat (2) add_hdr(8'h00);
        repeat (3) add_hdr(8'h00);
        add_typed(8'h00, make_res(KIND_END, 8'h00, 1'b0, 1'b1, 16'd0, 32'd0,
                                  32'hFFFF_FFFF));
        // Record with zero outer length, a two-byte name and a one-byte payload.
        repeat (4) add_hdr(8'h00);
        add_hdr(8'h00);
        add_hdr(8'h02);
        add_plain(8'h80);
        add_typed(8'hFF, make_res(KIND_NAME, 8'hFF, 1'b1, 1'b0, 16'd2, 32'd0, 32'd0));
        repeat (3) add_hdr(8'h00);
        add_hdr(8'h01);
        add_typed(8'h00, make_res(KIND_PAYLOAD, 8'h00, 1'b1, 1'b1, 16'd2, 32'd1,
                                  32'd0));

        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            send_byte(dir_tab[i].data, dir_tab[i].typed, dir_tab[i].gives,
                      dir_tab[i].exp);
        end
        records_sent = 2;

        // Random records; idling varies by stretch and stops near the end.
        while (bytes_sent < 450) begin
            if (bytes_sent >= 150 && !paused) begin
                // Hold the sender off until the output side has drained.
                paused = 1'b1;
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (due_results.size() != 0);
            end
            gaps_on   = (bytes_sent < 150) || (bytes_sent >= 250 && bytes_sent < 370);
            stalls_on = (bytes_sent < 150) || (bytes_sent >= 200 && bytes_sent < 310);
            if (bigs_left != 0 && $urandom_range(0, 11) == 0) begin
                bigs_left--;
                send_record(1'b1);
            end else begin
                send_record(1'b0);
            end
        end

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (due_results.size() != 0);
        repeat (8) @(posedge i_clk);
        if (due_results.size() != 0) begin
            report_mismatch($sformatf("%0d transfers never arrived", due_results.size()));
        end

        $display("Fed %0d bytes in %0d records, idling on and off at both ends.",
                 bytes_sent, records_sent);
        $display("Checked %0d name bytes, %0d payload bytes and %0d empty-payload ends.",
                 name_seen, payload_seen, end_seen);
        if (err_cnt == 0) begin
            $display("[length_prefixed_record_deframer] OK");
        end else begin
            $display("[length_prefixed_record_deframer] ERROR");
        end
        $finish;
    end

endmodule
